[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the UTF-8 check core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clk edge outside reset.
`define U8VE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clk edge, reset included.
`define U8VE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/u8ve_pkg.sv]
// ----------------------------------------------------------------------------
// u8ve_pkg
// Types, constants and helpers shared by the UTF-8 check and escape core.
// ----------------------------------------------------------------------------
package u8ve_pkg;

  // Lead byte tags
  localparam logic [2:0] LEAD2_TAG = 3'h6;   // 110xxxxx
  localparam logic [3:0] LEAD3_TAG = 4'he;   // 1110xxxx
  localparam logic [4:0] LEAD4_TAG = 5'h1e;  // 11110xxx
  localparam logic [1:0] CONT_TAG  = 2'h2;   // 10xxxxxx

  // Escape text characters
  localparam logic [7:0] CH_LT  = 8'h3c;  // '<'
  localparam logic [7:0] CH_BSL = 8'h5c;  // '\'
  localparam logic [7:0] CH_X   = 8'h78;  // 'x'
  localparam logic [7:0] CH_GT  = 8'h3e;  // '>'
  localparam logic [7:0] CH_0   = 8'h30;  // '0'
  localparam logic [7:0] CH_A10 = 8'h57;  // 'a' - 10

  // Job queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Output position within one job (max 12 chars)
  localparam int POS_W = 4;

  typedef enum logic {
    JOB_RAW,
    JOB_ESC
  } job_kind_t;

  // One unit of work for the serializer: 1..4 bytes, sent raw or escaped.
  typedef struct packed {
    job_kind_t       kind;
    logic [1:0]      nm1;     // byte count minus one
    logic [3:0][7:0] bytes;   // lead byte at index 0
  } job_t;

  // Number of continuation bytes a lead byte opens, 0 if not a lead byte.
  function automatic logic [1:0] lead_len(input logic [7:0] b);
    logic [1:0] len;
    len = 2'd0;
    if (b[7:5] == LEAD2_TAG) begin
      len = 2'd1;
    end else if (b[7:4] == LEAD3_TAG) begin
      len = 2'd2;
    end else if (b[7:3] == LEAD4_TAG) begin
      len = 2'd3;
    end
    return len;
  endfunction

  // Lowercase hex digit.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = CH_0 + {4'h0, n};
    end else begin
      c = CH_A10 + {4'h0, n};
    end
    return c;
  endfunction

endpackage

[rtl/core/u8ve_front.sv]
// ----------------------------------------------------------------------------
// u8ve_front
// Byte intake: tracks open sequences and turns finished ones into jobs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8ve_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  output logic            in_stall,
  input  logic            q_full,
  output logic            push,
  output u8ve_pkg::job_t  push_job
);
  import u8ve_pkg::*;

  logic [3:0][7:0] seq_r, seq_nxt;
  logic [1:0]      exp_r, exp_nxt;
  logic [1:0]      rcv_r, rcv_nxt;

  logic            take;
  logic [1:0]      idx;
  logic [1:0]      rcv_inc;
  logic [1:0]      len;
  logic [3:0][7:0] merged;
  logic            cont_ok;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;
  assign idx      = rcv_r + 2'd1;
  assign rcv_inc  = rcv_r + 2'd1;
  assign len      = lead_len(in_byte);

  always_comb begin
    merged      = seq_r;
    merged[idx] = in_byte;
    cont_ok     = 1'b1;
    for (int k = 1; k < 4; k++) begin
      if ((2'(k) <= exp_r) && (merged[k][7:6] != CONT_TAG)) begin
        cont_ok = 1'b0;
      end
    end
  end

  always_comb begin
    seq_nxt        = seq_r;
    exp_nxt        = exp_r;
    rcv_nxt        = rcv_r;
    push           = 1'b0;
    push_job.kind  = JOB_RAW;
    push_job.nm1   = 2'd0;
    push_job.bytes = merged;
    if (take) begin
      if (exp_r == 2'd0) begin
        push_job.bytes[0] = in_byte;
        if (!in_byte[7]) begin
          push = 1'b1;
        end else if (len == 2'd0) begin
          push          = 1'b1;
          push_job.kind = JOB_ESC;
        end else begin
          seq_nxt[0] = in_byte;
          exp_nxt    = len;
          rcv_nxt    = 2'd0;
        end
      end else begin
        seq_nxt = merged;
        rcv_nxt = rcv_inc;
        if (rcv_inc == exp_r) begin
          push          = 1'b1;
          push_job.kind = cont_ok ? JOB_RAW : JOB_ESC;
          push_job.nm1  = exp_r;
          exp_nxt       = 2'd0;
          rcv_nxt       = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= 2'd0;
      rcv_r <= 2'd0;
    end else begin
      exp_r <= exp_nxt;
      rcv_r <= rcv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r <= seq_nxt;
  end

  `U8VE_ASSERT(a_rcv_below_exp, (exp_r == 2'd0) ? (rcv_r == 2'd0) : (rcv_r < exp_r), "front: received count out of range")
  `U8VE_ASSERT(a_no_push_when_full, !(push && q_full), "front: push into full queue")

endmodule

[rtl/core/u8ve_jobq.sv]
// ----------------------------------------------------------------------------
// u8ve_jobq
// Small register queue of jobs between intake and serializer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8ve_jobq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  u8ve_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output u8ve_pkg::job_t  head
);
  import u8ve_pkg::*;

  job_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = entry_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_r] <= push_job;
    end
  end

  `U8VE_ASSERT(a_cnt_bound, cnt_r <= QCNT_W'(QDEPTH), "jobq: count above depth")
  `U8VE_ASSERT(a_no_pop_empty, !(pop && !head_valid), "jobq: pop from empty queue")

endmodule

[rtl/core/u8ve_back.sv]
// ----------------------------------------------------------------------------
// u8ve_back
// Serializer: emits the queue head as output bytes, one per unstalled cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8ve_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  u8ve_pkg::job_t  head,
  output logic            pop,
  output logic            out_valid,
  output logic [7:0]      out_byte,
  output logic            out_run_last,
  input  logic            out_stall
);
  import u8ve_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       ob_r, ob_nxt;
  logic             ol_r, ol_nxt;

  logic             load;
  logic             emit;
  logic [POS_W-1:0] last_pos;
  logic [POS_W-1:0] hex_idx;
  logic [7:0]       hex_src;
  logic [7:0]       ch;
  logic             is_last;

  assign load    = !ov_r || !out_stall;
  assign emit    = load && head_valid;
  assign hex_idx = pos_r - POS_W'(3);
  assign hex_src = head.bytes[hex_idx[2:1]];

  always_comb begin
    if (head.kind == JOB_RAW) begin
      last_pos = {2'b00, head.nm1};
      ch       = head.bytes[pos_r[1:0]];
    end else begin
      // '<' '\' 'x' then two digits per byte then '>'
      last_pos = POS_W'(5) + {1'b0, head.nm1, 1'b0};
      if (pos_r == POS_W'(0)) begin
        ch = CH_LT;
      end else if (pos_r == POS_W'(1)) begin
        ch = CH_BSL;
      end else if (pos_r == POS_W'(2)) begin
        ch = CH_X;
      end else if (pos_r == last_pos) begin
        ch = CH_GT;
      end else begin
        ch = hex_char(hex_idx[0] ? hex_src[3:0] : hex_src[7:4]);
      end
    end
    is_last = (pos_r == last_pos);
  end

  assign pop = emit && is_last;

  always_comb begin
    pos_nxt = pos_r;
    ov_nxt  = ov_r;
    ob_nxt  = ob_r;
    ol_nxt  = ol_r;
    if (emit) begin
      ov_nxt  = 1'b1;
      ob_nxt  = ch;
      ol_nxt  = is_last;
      pos_nxt = is_last ? '0 : pos_r + 1'b1;
    end else if (load) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob_r <= ob_nxt;
    ol_r <= ol_nxt;
  end

  assign out_valid    = ov_r;
  assign out_byte     = ob_r;
  assign out_run_last = ol_r;

  `U8VE_ASSERT(a_pos_in_job, head_valid ? (pos_r <= last_pos) : (pos_r == '0), "back: position past end of job")

endmodule

[rtl/core/utf8_stream_validate_escape.sv]
// ----------------------------------------------------------------------------
// utf8_stream_validate_escape
// UTF-8 stream check with lowercase hex escapes of bad bytes and sequences.
// ----------------------------------------------------------------------------
// One raw byte is taken per cycle on in_*; text bytes leave on out_*, one per
// cycle, with out_run_last high on the last byte caused by an input item.
// ASCII passes through. A lead byte (110xxxxx, 1110xxxx, 11110xxx) opens a
// sequence of 1..3 continuation bytes; the sequence produces nothing until
// its last byte arrives, then it leaves raw if every continuation byte is
// 10xxxxxx and otherwise as one escape "<\x" + hex pairs + ">". Any other
// byte outside a sequence leaves as "<\xHH>". Overlong forms and surrogates
// are not flagged, and the lead byte itself is not checked. While a sequence
// is open every byte, ASCII included, counts as its next byte.
// Rate: intake sustains one item per cycle as long as the job queue has room;
// the output side is the bottleneck, at one byte per cycle while out_stall is
// low: a passed byte or a valid n-byte sequence yields 1 or n output bytes,
// an escape of n bytes yields 2n+4 (6 for a single bad byte, up to 12). From
// input acceptance to the first output byte a job passes the job queue, then
// the output register. There is no post-reset clearing pass.
// ----------------------------------------------------------------------------
module utf8_stream_validate_escape (
  input  logic       clk,
  input  logic       rst_n,
  // input byte channel
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_stall,
  // output text channel
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  input  logic       out_stall
);
  import u8ve_pkg::*;

  logic q_full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head;

  // Front: sequence tracking and job building. Stalls only on a full queue.
  u8ve_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_stall (in_stall),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // Job queue decouples intake from the serializer's bursts.
  u8ve_jobq u_jobq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: walks the head job into the output register, one char per unstalled cycle.
  u8ve_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .out_stall    (out_stall)
  );

endmodule
